/* rtl/tcws_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcws_pkg
// Shared types and constants of the two-channel window statistics block.
// ----------------------------------------------------------------------------
package tcws_pkg;

  localparam int SampleW  = 12;
  localparam int CountW   = 16;
  localparam int MeanW    = 20;
  localparam int MeanFrac = 8;

  typedef enum logic {
    CmdSample = 1'b0,
    CmdClear  = 1'b1
  } tcws_cmd_e;

  typedef struct packed {
    tcws_cmd_e           cmd;
    logic [SampleW-1:0]  sample_a;
    logic [SampleW-1:0]  sample_b;
  } tcws_in_t;

  typedef struct packed {
    logic [CountW-1:0]   sample_count;
    logic [SampleW-1:0]  max_a;
    logic [SampleW-1:0]  min_a;
    logic [MeanW-1:0]    mean_a;
    logic [SampleW-1:0]  max_b;
    logic [SampleW-1:0]  min_b;
    logic [MeanW-1:0]    mean_b;
  } tcws_out_t;

  // per-lane strobes from the sequencer
  typedef struct packed {
    logic clr;    // zero sum and extremes
    logic rd;     // read ring slot leaving the window
    logic upd;    // write ring, update sum/extremes, start divider
    logic first;  // first sample since clear
    logic full;   // window already full
  } tcws_lane_ctrl_t;

endpackage
`default_nettype wire

/* rtl/tcws_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcws_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcws_div
  import tcws_pkg::*;
#(
  parameter int DVD_W = 28,
  parameter int DVS_W = 9
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  busy_o,
  output logic [MeanW-1:0]      quotient_o
);

  localparam int CntW = $clog2(DVD_W);

  logic             busy_q;
  logic [CntW-1:0]  cnt_q;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   shifted, diff;
  logic             take;

  always_comb begin
    shifted = {rem_q, dvd_q[DVD_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    take    = ~diff[DVS_W];
    rem_d   = take ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    // quotient bits shift in behind the consumed dividend bits
    dvd_d   = {dvd_q[DVD_W-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(DVD_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = dvd_q[MeanW-1:0];

endmodule
`default_nettype wire

/* rtl/tcws_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcws_lane
// One channel: sample ring, running window sum, extremes and mean divider.
// ----------------------------------------------------------------------------
module tcws_lane
  import tcws_pkg::*;
#(
  parameter int WINDOW = 256
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire tcws_lane_ctrl_t              ctrl_i,
  input  wire logic [$clog2(WINDOW)-1:0]    addr_i,
  input  wire logic [$clog2(WINDOW+1)-1:0]  divisor_i,
  input  wire logic [SampleW-1:0]           sample_i,
  output logic                              busy_o,
  output logic [SampleW-1:0]                peak_o,
  output logic [SampleW-1:0]                trough_o,
  output logic [MeanW-1:0]                  mean_o
);

  localparam int NW   = $clog2(WINDOW + 1);
  localparam int SumW = $clog2(WINDOW * ((1 << SampleW) - 1) + 1);

  logic [SampleW-1:0] ring_mem [WINDOW];
  logic [SampleW-1:0] old_q;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [SampleW-1:0] peak_q, trough_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd) begin
      ring_mem[addr_i] <= sample_i;
    end
    if (ctrl_i.rd) begin
      old_q <= ring_mem[addr_i];
    end
  end

  always_comb begin
    if (ctrl_i.full) begin
      sum_d = sum_q - SumW'(old_q) + SumW'(sample_i);
    end else begin
      sum_d = sum_q + SumW'(sample_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      peak_q   <= '0;
      trough_q <= '0;
    end else if (ctrl_i.clr) begin
      sum_q    <= '0;
      peak_q   <= '0;
      trough_q <= '0;
    end else if (ctrl_i.upd) begin
      sum_q <= sum_d;
      if (ctrl_i.first) begin
        peak_q   <= sample_i;
        trough_q <= sample_i;
      end else begin
        if (sample_i > peak_q)   peak_q   <= sample_i;
        if (sample_i < trough_q) trough_q <= sample_i;
      end
    end
  end

  tcws_div #(
    .DVD_W (SumW + MeanFrac),
    .DVS_W (NW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.upd),
    .dividend_i ({sum_d, {MeanFrac{1'b0}}}),
    .divisor_i  (divisor_i),
    .busy_o     (busy_o),
    .quotient_o (mean_o)
  );

  assign peak_o   = peak_q;
  assign trough_o = trough_q;

endmodule
`default_nettype wire

/* rtl/two_channel_window_statistics.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// two_channel_window_statistics
// Per-channel min/max since clear and sliding-window mean of two channels.
// ----------------------------------------------------------------------------
// Each transaction is a sample pair or a clear and returns one result with
// the statistics as they stand. Items are handled one at a time. A sample
// pair is held while the bit-serial divider in each lane produces one bit of
// the 12.8 mean per cycle over the SumW + 8 bit dividend, where SumW =
// clog2(WINDOW * 4095 + 1); both lanes divide side by side. The result
// register lets the next item be accepted while a result still waits on
// the output.
module two_channel_window_statistics
  import tcws_pkg::*;
#(
  parameter int WINDOW = 256
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire tcws_in_t  in_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output tcws_out_t      out_o
);

  localparam int PtrW = $clog2(WINDOW);
  localparam int CntW = $clog2(WINDOW + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_OUT
  } state_e;

  state_e            state_q;
  tcws_in_t          in_q;
  tcws_out_t         out_q, out_d;
  logic              out_valid_q;
  logic [PtrW-1:0]   wp_q;
  logic [CntW-1:0]   fill_q;
  logic [CountW-1:0] count_q;

  tcws_lane_ctrl_t   ctrl;
  logic [CntW-1:0]   divisor;
  logic              in_fire, full;
  logic              busy_a, busy_b;
  logic [SampleW-1:0] peak_a, trough_a, peak_b, trough_b;
  logic [MeanW-1:0]  mean_a, mean_b;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (fill_q == CntW'(WINDOW));
  assign divisor    = full ? CntW'(WINDOW) : fill_q + 1'b1;

  always_comb begin
    ctrl       = '0;
    ctrl.clr   = in_fire && (in_i.cmd == CmdClear);
    ctrl.rd    = in_fire && (in_i.cmd == CmdSample);
    ctrl.upd   = (state_q == S_READ);
    ctrl.first = (fill_q == '0);
    ctrl.full  = full;
  end

  tcws_lane #(.WINDOW(WINDOW)) u_lane_a (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .addr_i    (wp_q),
    .divisor_i (divisor),
    .sample_i  (in_q.sample_a),
    .busy_o    (busy_a),
    .peak_o    (peak_a),
    .trough_o  (trough_a),
    .mean_o    (mean_a)
  );

  tcws_lane #(.WINDOW(WINDOW)) u_lane_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .addr_i    (wp_q),
    .divisor_i (divisor),
    .sample_i  (in_q.sample_b),
    .busy_o    (busy_b),
    .peak_o    (peak_b),
    .trough_o  (trough_b),
    .mean_o    (mean_b)
  );

  // merge the lane results; a clear reports all zero
  always_comb begin
    out_d = '0;
    if (in_q.cmd == CmdSample) begin
      out_d.sample_count = count_q;
      out_d.max_a        = peak_a;
      out_d.min_a        = trough_a;
      out_d.mean_a       = mean_a;
      out_d.max_b        = peak_b;
      out_d.min_b        = trough_b;
      out_d.mean_b       = mean_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_q        <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      wp_q        <= '0;
      fill_q      <= '0;
      count_q     <= '0;
    end else begin
      // in S_OUT the output slot is handled below
      if (out_valid_q && out_ready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            in_q <= in_i;
            if (in_i.cmd == CmdClear) begin
              wp_q    <= '0;
              fill_q  <= '0;
              count_q <= '0;
              state_q <= S_OUT;
            end else begin
              state_q <= S_READ;
            end
          end
        end
        S_READ: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (!busy_a && !busy_b) begin
            wp_q    <= (wp_q == PtrW'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
            if (!full) fill_q <= fill_q + 1'b1;
            count_q <= count_q + 1'b1;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= out_d;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // both lanes divide in lockstep
  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_a == busy_b)
    else $error("lane dividers out of step");

  a_busy_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_a |-> state_q == S_DIV)
    else $error("divider running outside the divide state");

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.cmd == CmdClear) |=>
      (fill_q == '0 && wp_q == '0 && count_q == '0))
    else $error("clear left window state behind");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && !busy_a && full) |=> full)
    else $error("fill count passed the window size");

endmodule
`default_nettype wire

/* dv/two_channel_window_statistics_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_channel_window_statistics_checker
// Watches both channels of the window statistics block. It predicts every
// result and compares the results that arrive.
// ----------------------------------------------------------------------------
// Each accepted input transaction runs through a local copy of the statistics
// state: extremes, ring stores, running sums and the sample counter. The
// predicted result is queued. Each accepted output transaction is compared
// field by field with the oldest queued result.
module two_channel_window_statistics_checker
  import tcws_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  tcws_in_t    in_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  tcws_out_t   out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  localparam int Window    = 256;
  localparam int SumW      = 20;
  localparam int PrintMax  = 20;

  // predicted block state
  logic [SampleW-1:0] ring_a [Window];
  logic [SampleW-1:0] ring_b [Window];
  logic [7:0]         wr_ptr;
  logic [8:0]         fill;
  logic [SumW-1:0]    sum_a, sum_b;
  logic [SampleW-1:0] peak_a, trough_a, peak_b, trough_b;
  logic [MeanW-1:0]   avg_a, avg_b;
  logic [CountW-1:0]  taken;

  tcws_out_t   expected_stats [$];
  tcws_out_t   want_res, new_res;
  int unsigned mismatch_count = 0;
  int unsigned checked_count  = 0;

  task automatic clear_model();
    wr_ptr   = '0;
    fill     = '0;
    sum_a    = '0;
    sum_b    = '0;
    peak_a   = '0;
    trough_a = '0;
    peak_b   = '0;
    trough_b = '0;
    avg_a    = '0;
    avg_b    = '0;
    taken    = '0;
  endtask

  function automatic logic [MeanW-1:0] window_mean(logic [SumW-1:0] sum, int unsigned n);
    return MeanW'((32'(sum) << MeanFrac) / n);
  endfunction

  task automatic predict_stats(input tcws_in_t item, output tcws_out_t res);
    int unsigned divisor;
    if (item.cmd == CmdClear) begin
      clear_model();
    end else begin
      taken = taken + 1'b1;
      if (fill == 0) begin
        peak_a   = item.sample_a;
        trough_a = item.sample_a;
        peak_b   = item.sample_b;
        trough_b = item.sample_b;
      end else begin
        if (item.sample_a > peak_a)   peak_a   = item.sample_a;
        if (item.sample_a < trough_a) trough_a = item.sample_a;
        if (item.sample_b > peak_b)   peak_b   = item.sample_b;
        if (item.sample_b < trough_b) trough_b = item.sample_b;
      end
      // full window: the slot about to be overwritten leaves the sum
      if (fill == Window) begin
        sum_a   = sum_a - ring_a[wr_ptr] + item.sample_a;
        sum_b   = sum_b - ring_b[wr_ptr] + item.sample_b;
        divisor = Window;
      end else begin
        sum_a   = sum_a + item.sample_a;
        sum_b   = sum_b + item.sample_b;
        divisor = fill + 1;
      end
      avg_a = window_mean(sum_a, divisor);
      avg_b = window_mean(sum_b, divisor);
      ring_a[wr_ptr] = item.sample_a;
      ring_b[wr_ptr] = item.sample_b;
      wr_ptr = (wr_ptr == Window - 1) ? '0 : wr_ptr + 1'b1;
      if (fill < Window) fill = fill + 1'b1;
    end
    res.sample_count = taken;
    res.max_a        = peak_a;
    res.min_a        = trough_a;
    res.mean_a       = avg_a;
    res.max_b        = peak_b;
    res.min_b        = trough_b;
    res.mean_b       = avg_b;
  endtask

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PrintMax) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                checked_count, name, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
      for (int i = 0; i < Window; i++) begin
        ring_a[i] = '0;
        ring_b[i] = '0;
      end
      expected_stats.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      // compare before queuing: a result never leaves on its own input's edge
      if (out_valid_i && out_ready_i) begin
        if (expected_stats.size() == 0) begin
          report_mismatch($sformatf("result with no transaction pending, count %0h",
                                    out_i.sample_count));
        end else begin
          want_res = expected_stats.pop_front();
          compare_field("sample_count", out_i.sample_count, want_res.sample_count);
          compare_field("max_a",        out_i.max_a,        want_res.max_a);
          compare_field("min_a",        out_i.min_a,        want_res.min_a);
          compare_field("mean_a",       out_i.mean_a,       want_res.mean_a);
          compare_field("max_b",        out_i.max_b,        want_res.max_b);
          compare_field("min_b",        out_i.min_b,        want_res.min_b);
          compare_field("mean_b",       out_i.mean_b,       want_res.mean_b);
          checked_count++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_stats(in_i, new_res);
        expected_stats.push_back(new_res);
      end
      fail_count_o <= mismatch_count;
      pending_o    <= expected_stats.size();
      checked_o    <= checked_count;
    end
  end

endmodule

/* dv/tb_two_channel_window_statistics.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_channel_window_statistics
// Stimulus and verdict for the two-channel window statistics block.
// ----------------------------------------------------------------------------
// A directed opening hits the code extremes, clears and first samples after a
// clear. Random segments follow: long sample runs that can wrap the window and
// short runs, each with its own code style, and mixed noise. The sender works in
// bursts and the receiver stalls on patterns. A checker predicts and compares.
module tb_two_channel_window_statistics;
  import tcws_pkg::*;

  localparam int RandomItems = 1600;
  localparam int TailCycles  = 64;
  localparam int StallLimit  = 2000;

  logic      clk_i = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  tcws_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  tcws_out_t out_data;

  int unsigned stats_fails, stats_pending, stats_checked;

  int unsigned burst_left   = 4;
  int unsigned samples_sent = 0;
  int unsigned clears_sent  = 0;
  int unsigned run_len      = 0;
  int unsigned longest_run  = 0;
  int unsigned random_sent  = 0;
  int unsigned idle_cycles  = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  two_channel_window_statistics u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data)
  );

  two_channel_window_statistics_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_i         (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_i        (out_data),
    .fail_count_o (stats_fails),
    .pending_o    (stats_pending),
    .checked_o    (stats_checked)
  );

  // receiver: ready pattern re-chosen at random intervals
  int unsigned rx_mode = 0, rx_phase = 0, rx_period = 1, rx_low = 0, rx_left = 0;

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_left   = $urandom_range(50, 400);
      rx_mode   = $urandom_range(0, 3);
      rx_phase  = 0;
      rx_period = $urandom_range(8, 48);
      rx_low    = $urandom_range(1, rx_period - 1);
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) >= 3);
      default: out_ready <= (rx_phase >= rx_low);
    endcase
    rx_phase = (rx_phase + 1 >= rx_period) ? 0 : rx_phase + 1;
    rx_left--;
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("stall: no transaction for %0d cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(input tcws_cmd_e cmd, input logic [SampleW-1:0] a,
                           input logic [SampleW-1:0] b);
    tcws_in_t item;
    item.cmd      = cmd;
    item.sample_a = a;
    item.sample_b = b;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (cmd == CmdClear) begin
      clears_sent++;
      run_len = 0;
    end else begin
      samples_sent++;
      run_len++;
      if (run_len > longest_run) longest_run = run_len;
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (stats_pending != 0);
  endtask

  // code styles: full range, rails only, narrow band, flat with spikes
  function automatic logic [SampleW-1:0] pick_code(int unsigned style,
                                                   logic [SampleW-1:0] base);
    case (style)
      0: return SampleW'($urandom_range(0, 4095));
      1: return $urandom_range(0, 1) ? {SampleW{1'b1}} : '0;
      2: return base ^ SampleW'($urandom_range(0, 31));
      default: return ($urandom_range(0, 19) == 0) ? SampleW'($urandom_range(0, 4095)) : base;
    endcase
  endfunction

  initial begin
    int unsigned kind, len, style_a, style_b;
    logic [SampleW-1:0] base_a, base_b;

    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, alternating bits, clears, first sample after clear
    send_item(CmdSample, 12'h000, 12'hFFF);
    send_item(CmdSample, 12'hFFF, 12'h000);
    send_item(CmdSample, 12'h800, 12'h7FF);
    send_item(CmdSample, 12'hAAA, 12'h555);
    send_item(CmdSample, 12'h555, 12'hAAA);
    send_item(CmdSample, 12'h001, 12'hFFE);
    send_item(CmdClear,  12'hFFF, 12'hFFF);
    send_item(CmdClear,  12'h000, 12'h000);
    send_item(CmdSample, 12'hFFF, 12'hFFF);
    send_item(CmdSample, 12'h000, 12'h000);
    send_item(CmdSample, 12'h7FF, 12'h800);
    send_item(CmdClear,  12'h5A5, 12'hA5A);
    send_item(CmdSample, 12'h000, 12'h000);
    send_item(CmdSample, 12'h003, 12'h001);
    send_item(CmdSample, 12'h000, 12'h002);
    send_item(CmdClear,  12'hA5A, 12'h5A5);
    wait_for_results();

    while (random_sent < RandomItems) begin
      kind    = $urandom_range(0, 9);
      style_a = $urandom_range(0, 3);
      style_b = $urandom_range(0, 3);
      base_a  = SampleW'($urandom_range(0, 4095));
      base_b  = SampleW'($urandom_range(0, 4095));
      if (kind < 7) begin
        // short runs stay in the fill phase, long ones can wrap the ring
        len = (kind < 2) ? $urandom_range(1, 12) : $urandom_range(200, 600);
        if (len > RandomItems - random_sent) len = RandomItems - random_sent;
        repeat (len) begin
          send_item(CmdSample, pick_code(style_a, base_a), pick_code(style_b, base_b));
          random_sent++;
        end
        send_item(CmdClear, SampleW'($urandom_range(0, 4095)),
                  SampleW'($urandom_range(0, 4095)));
        random_sent++;
      end else begin
        repeat ($urandom_range(5, 20)) begin
          send_item(($urandom_range(0, 9) < 3) ? CmdClear : CmdSample,
                    SampleW'($urandom_range(0, 4095)), SampleW'($urandom_range(0, 4095)));
          random_sent++;
        end
      end
      if ($urandom_range(0, 2) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (TailCycles) @(posedge clk_i);

    $display("sent %0d sample pairs and %0d clears, longest run without clear %0d",
             samples_sent, clears_sent, longest_run);
    $display("checked %0d results, %0d mismatches", stats_checked, stats_fails);
    if (stats_fails == 0 && stats_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
